[src/tbc_pkg.sv]
// Package for the tetrahedron barycentric coordinate core.
// Holds widths, micro-op encodings and the per-face micro-op table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tbc_pkg;

  localparam int CW  = 24;  // coordinate width, Q7.16
  localparam int DW  = 25;  // coordinate difference
  localparam int BW  = 27;  // multiplier B operand
  localparam int PW  = DW + BW;  // product width
  localparam int NVW = 51;  // normal vector component
  localparam int NLW = 26;  // low split of a normal component
  localparam int AW  = 78;  // dot product accumulator
  localparam int QW  = 25;  // raw quotient bits

  localparam logic [4:0] LAST_STEP = 5'd17;
  localparam logic [1:0] LAST_FACE = 2'd3;

  typedef enum logic [3:0] {
    A_E1X, A_E1Y, A_E1Z, A_DXX, A_DXY, A_DXZ, A_DVX, A_DVY, A_DVZ
  } asel_t;

  typedef enum logic [3:0] {
    B_E2X, B_E2Y, B_E2Z, B_NV0L, B_NV0H, B_NV1L, B_NV1H, B_NV2L, B_NV2H
  } bsel_t;

  typedef enum logic [2:0] {
    D_NONE, D_NV0, D_NV1, D_NV2, D_NUM, D_DEN
  } dest_t;

  typedef struct packed {
    asel_t asel;
    bsel_t bsel;
    logic  ld;
    logic  sub;
    dest_t dest;
  } uop_t;

  // control beat that travels with a product through the MAC
  typedef struct packed {
    logic       valid;
    logic       hi;     // B operand is the upper half of a normal component
    logic       ld;     // start a new sum
    logic       sub;
    dest_t      dest;
    logic [1:0] face;
  } mac_ctl_t;

  // One face: cross product n = e1 x e2, then dot(dx, n), then dot(dv, n).
  function automatic uop_t uop_rom(input logic [4:0] step);
    uop_t u;
    u = '{asel: A_E1X, bsel: B_E2X, ld: 1'b0, sub: 1'b0, dest: D_NONE};
    unique case (step)
      5'd0:  u = '{A_E1Y, B_E2Z,  1'b1, 1'b0, D_NONE};
      5'd1:  u = '{A_E1Z, B_E2Y,  1'b0, 1'b1, D_NV0};
      5'd2:  u = '{A_E1Z, B_E2X,  1'b1, 1'b0, D_NONE};
      5'd3:  u = '{A_E1X, B_E2Z,  1'b0, 1'b1, D_NV1};
      5'd4:  u = '{A_E1X, B_E2Y,  1'b1, 1'b0, D_NONE};
      5'd5:  u = '{A_E1Y, B_E2X,  1'b0, 1'b1, D_NV2};
      5'd6:  u = '{A_DXX, B_NV0L, 1'b1, 1'b0, D_NONE};
      5'd7:  u = '{A_DXX, B_NV0H, 1'b0, 1'b0, D_NONE};
      5'd8:  u = '{A_DXY, B_NV1L, 1'b0, 1'b0, D_NONE};
      5'd9:  u = '{A_DXY, B_NV1H, 1'b0, 1'b0, D_NONE};
      5'd10: u = '{A_DXZ, B_NV2L, 1'b0, 1'b0, D_NONE};
      5'd11: u = '{A_DXZ, B_NV2H, 1'b0, 1'b0, D_NUM};
      5'd12: u = '{A_DVX, B_NV0L, 1'b1, 1'b0, D_NONE};
      5'd13: u = '{A_DVX, B_NV0H, 1'b0, 1'b0, D_NONE};
      5'd14: u = '{A_DVY, B_NV1L, 1'b0, 1'b0, D_NONE};
      5'd15: u = '{A_DVY, B_NV1H, 1'b0, 1'b0, D_NONE};
      5'd16: u = '{A_DVZ, B_NV2L, 1'b0, 1'b0, D_NONE};
      5'd17: u = '{A_DVZ, B_NV2H, 1'b0, 1'b0, D_DEN};
      default: u = '{A_E1X, B_E2X, 1'b0, 1'b0, D_NONE};
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

[src/tbc_mac.sv]
// Shared multiply-accumulate unit: 25x27 signed multiply, registered,
// then a 78-bit accumulate with optional 26-bit upshift. Uses tbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tbc_mac import tbc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic signed [DW-1:0] op_a,
  input  wire logic signed [BW-1:0] op_b,
  input  wire mac_ctl_t             ctl_in,
  output logic signed [AW-1:0]      acc_sum,
  output mac_ctl_t                  ctl_q
);

  logic signed [PW-1:0] prod_r;
  logic signed [AW-1:0] acc_r;
  logic signed [AW-1:0] ext;
  logic signed [AW-1:0] term;
  mac_ctl_t             ctl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
    if (ctl_r.valid) begin
      acc_r <= acc_sum;
    end
  end

  always_comb begin
    ext     = AW'(prod_r);
    term    = ctl_r.hi ? (ext <<< NLW) : ext;
    acc_sum = (ctl_r.ld ? '0 : acc_r) + (ctl_r.sub ? -term : term);
  end

  assign ctl_q = ctl_r;

endmodule

`default_nettype wire

[src/tbc_div.sv]
// Restoring divider: num * 2^16 / den, truncated toward zero, one
// quotient bit per cycle, saturated to 24 bits. Uses tbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tbc_div import tbc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic signed [AW-1:0] num,
  input  wire logic signed [AW-1:0] den,
  output logic                      done,
  output logic signed [CW-1:0]      quot
);

  localparam int RW = AW + 24;

  logic          busy_r;
  logic          fin_r;
  logic [4:0]    cnt_r;
  logic [RW-1:0] rem_r;
  logic [RW-1:0] dvs_r;
  logic [QW-1:0] q_r;
  logic          neg_r;
  logic [AW-1:0] nmag;
  logic [AW-1:0] dmag;
  logic [RW:0]   diff;

  assign nmag = num[AW-1] ? AW'(-num) : AW'(num);
  assign dmag = den[AW-1] ? AW'(-den) : AW'(den);
  assign diff = {1'b0, rem_r} - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
    end else begin
      fin_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 5'(QW - 1)) begin
        busy_r <= 1'b0;
        fin_r  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= '0;
      rem_r <= {8'b0, nmag, 16'b0};
      dvs_r <= {dmag, 24'b0};
      q_r   <= '0;
      neg_r <= num[AW-1] ^ den[AW-1];
    end else if (busy_r) begin
      cnt_r <= cnt_r + 5'd1;
      dvs_r <= dvs_r >> 1;
      if (!diff[RW]) begin
        rem_r <= diff[RW-1:0];
      end
      q_r <= {q_r[QW-2:0], ~diff[RW]};
    end
  end

  always_comb begin
    if (neg_r) begin
      quot = (q_r > QW'(24'h800000)) ? CW'(24'h800000) : CW'(-q_r);
    end else begin
      quot = (q_r > QW'(24'h7FFFFF)) ? CW'(24'h7FFFFF) : q_r[CW-1:0];
    end
  end

  assign done = fin_r;

endmodule

`default_nettype wire

[src/tetra_barycentric_coords_core.sv]
// Top level of the tetrahedron barycentric coordinate core.
// Uses tbc_pkg, tbc_mac (shared multiplier) and tbc_div (shared divider).
`timescale 1ns / 1ps
`default_nettype none

// Holds the four vertices of a tetrahedron and returns, for each query
// point, the four barycentric weights in signed Q7.16 plus a degenerate
// flag. A beat with req_type 0 writes one vertex and yields no result; a
// beat with req_type 1 is a query and yields exactly one result beat. The
// block takes one beat at a time and is not ready while a query is in
// flight. A query's result passes through the single 25x27 multiplier
// (18 multiply-accumulate steps for each of the four faces: face normal,
// then its dot products with the point and with the opposite vertex), a
// drain state, four divisions on the one shared divider (each a start,
// 25 restoring steps and a finish), and the load of the output register.
// The divider sets most of the latency. The block is ready again in
// the cycle the result appears. A degenerate tetrahedron (any zero
// denominator) skips the divisions and returns zero weights.
// Each face uses the three other vertices in cyclic order rather than
// ascending order; a cyclic reorder keeps the face normal, so numerator
// and denominator come out the same. The result sits in an output
// register, so the next beat is taken while it waits; a finished query
// holds in its last cycle until that register is free.

module tetra_barycentric_coords_core import tbc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_req_type,
  input  wire logic [1:0]           in_vertex_index,
  input  wire logic signed [CW-1:0] in_coord_x,
  input  wire logic signed [CW-1:0] in_coord_y,
  input  wire logic signed [CW-1:0] in_coord_z,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [CW-1:0]      out_bary_0,
  output logic signed [CW-1:0]      out_bary_1,
  output logic signed [CW-1:0]      out_bary_2,
  output logic signed [CW-1:0]      out_bary_3,
  output logic                      out_degenerate
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MAC   = 5'b00010,
    S_DRAIN = 5'b00100,
    S_DIV   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state_r;

  // vertex store and working copy (rotated one vertex per face)
  logic signed [CW-1:0] vtx_r [4][3];
  logic signed [CW-1:0] w_r   [4][3];
  logic signed [CW-1:0] p_r   [3];

  logic signed [NVW-1:0] nv_r  [3];
  logic signed [AW-1:0]  num_r [4];
  logic signed [AW-1:0]  den_r [4];
  logic signed [CW-1:0]  res_r [4];
  logic signed [CW-1:0]  obary_r [4];
  logic                  odeg_r;
  logic                  out_valid_r;
  logic                  degen_r;

  logic [4:0] step_r;
  logic [1:0] face_r;
  logic [1:0] dface_r;
  logic       issued_r;

  logic signed [DW-1:0] e1 [3];
  logic signed [DW-1:0] e2 [3];
  logic signed [DW-1:0] dv [3];
  logic signed [DW-1:0] dx [3];

  uop_t                 uop;
  logic signed [DW-1:0] op_a;
  logic signed [BW-1:0] op_b;
  logic                 op_hi;
  mac_ctl_t             mac_ctl;
  mac_ctl_t             ctl_q;
  logic signed [AW-1:0] acc_sum;

  logic                 accept;
  logic                 div_start;
  logic                 div_done;
  logic signed [CW-1:0] div_q;
  logic                 out_load;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign div_start = (state_r == S_DIV) && !degen_r && !issued_r;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_ready);

  // face operands: w0 is the opposite vertex, w1..w3 span the face
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e1[k] = DW'(w_r[2][k]) - DW'(w_r[1][k]);
      e2[k] = DW'(w_r[3][k]) - DW'(w_r[1][k]);
      dv[k] = DW'(w_r[0][k]) - DW'(w_r[1][k]);
      dx[k] = DW'(p_r[k])    - DW'(w_r[1][k]);
    end
  end

  assign uop = uop_rom(step_r);

  always_comb begin
    unique case (uop.asel)
      A_E1X:   op_a = e1[0];
      A_E1Y:   op_a = e1[1];
      A_E1Z:   op_a = e1[2];
      A_DXX:   op_a = dx[0];
      A_DXY:   op_a = dx[1];
      A_DXZ:   op_a = dx[2];
      A_DVX:   op_a = dv[0];
      A_DVY:   op_a = dv[1];
      A_DVZ:   op_a = dv[2];
      default: op_a = '0;
    endcase
  end

  // normals are split: unsigned low 26 bits, signed upper 25 bits
  always_comb begin
    op_hi = 1'b0;
    unique case (uop.bsel)
      B_E2X:  op_b = BW'(e2[0]);
      B_E2Y:  op_b = BW'(e2[1]);
      B_E2Z:  op_b = BW'(e2[2]);
      B_NV0L: op_b = $signed({1'b0, nv_r[0][NLW-1:0]});
      B_NV1L: op_b = $signed({1'b0, nv_r[1][NLW-1:0]});
      B_NV2L: op_b = $signed({1'b0, nv_r[2][NLW-1:0]});
      B_NV0H: begin
        op_b  = BW'($signed(nv_r[0][NVW-1:NLW]));
        op_hi = 1'b1;
      end
      B_NV1H: begin
        op_b  = BW'($signed(nv_r[1][NVW-1:NLW]));
        op_hi = 1'b1;
      end
      B_NV2H: begin
        op_b  = BW'($signed(nv_r[2][NVW-1:NLW]));
        op_hi = 1'b1;
      end
      default: op_b = '0;
    endcase
  end

  always_comb begin
    mac_ctl.valid = (state_r == S_MAC);
    mac_ctl.hi    = op_hi;
    mac_ctl.ld    = uop.ld;
    mac_ctl.sub   = uop.sub;
    mac_ctl.dest  = uop.dest;
    mac_ctl.face  = face_r;
  end

  tbc_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .op_a    (op_a),
    .op_b    (op_b),
    .ctl_in  (mac_ctl),
    .acc_sum (acc_sum),
    .ctl_q   (ctl_q)
  );

  tbc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num_r[dface_r]),
    .den   (den_r[dface_r]),
    .done  (div_done),
    .quot  (div_q)
  );

  // vertex store, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int v = 0; v < 4; v++) begin
        for (int k = 0; k < 3; k++) begin
          vtx_r[v][k] <= '0;
        end
      end
    end else if (accept && !in_req_type) begin
      vtx_r[in_vertex_index][0] <= in_coord_x;
      vtx_r[in_vertex_index][1] <= in_coord_y;
      vtx_r[in_vertex_index][2] <= in_coord_z;
    end
  end

  // MAC writeback
  always_ff @(posedge clk) begin
    if (ctl_q.valid) begin
      unique case (ctl_q.dest)
        D_NV0:   nv_r[0] <= acc_sum[NVW-1:0];
        D_NV1:   nv_r[1] <= acc_sum[NVW-1:0];
        D_NV2:   nv_r[2] <= acc_sum[NVW-1:0];
        D_NUM:   num_r[ctl_q.face] <= acc_sum;
        D_DEN:   den_r[ctl_q.face] <= acc_sum;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degen_r <= 1'b0;
    end else if (accept && in_req_type) begin
      degen_r <= 1'b0;
    end else if (ctl_q.valid && ctl_q.dest == D_DEN && acc_sum == '0) begin
      degen_r <= 1'b1;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      step_r   <= '0;
      face_r   <= '0;
      dface_r  <= '0;
      issued_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept && in_req_type) begin
            step_r  <= '0;
            face_r  <= '0;
            state_r <= S_MAC;
          end
        end
        S_MAC: begin
          if (step_r == LAST_STEP) begin
            step_r <= '0;
            face_r <= face_r + 2'd1;
            if (face_r == LAST_FACE) begin
              state_r <= S_DRAIN;
            end
          end else begin
            step_r <= step_r + 5'd1;
          end
        end
        S_DRAIN: begin
          dface_r  <= '0;
          issued_r <= 1'b0;
          state_r  <= S_DIV;
        end
        S_DIV: begin
          if (degen_r) begin
            state_r <= S_OUT;
          end else begin
            if (div_start) begin
              issued_r <= 1'b1;
            end
            if (div_done) begin
              issued_r <= 1'b0;
              dface_r  <= dface_r + 2'd1;
              if (dface_r == LAST_FACE) begin
                state_r <= S_OUT;
              end
            end
          end
        end
        S_OUT: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // payload of the sequencer
  always_ff @(posedge clk) begin
    if (accept && in_req_type) begin
      p_r[0] <= in_coord_x;
      p_r[1] <= in_coord_y;
      p_r[2] <= in_coord_z;
      w_r    <= vtx_r;
    end else if (state_r == S_MAC && step_r == LAST_STEP) begin
      w_r[0] <= w_r[1];
      w_r[1] <= w_r[2];
      w_r[2] <= w_r[3];
      w_r[3] <= w_r[0];
    end
    if (state_r == S_DIV) begin
      if (degen_r) begin
        for (int f = 0; f < 4; f++) begin
          res_r[f] <= '0;
        end
      end else if (div_done) begin
        res_r[dface_r] <= div_q;
      end
    end
    if (out_load) begin
      obary_r <= res_r;
      odeg_r  <= degen_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_bary_0     = obary_r[0];
  assign out_bary_1     = obary_r[1];
  assign out_bary_2     = obary_r[2];
  assign out_bary_3     = obary_r[3];
  assign out_degenerate = odeg_r;

  // a degenerate result carries zero weights
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |->
      (out_bary_0 == '0 && out_bary_1 == '0 && out_bary_2 == '0 && out_bary_3 == '0))
    else $error("degenerate result with nonzero weight");

  // the divider is only started during the divide phase of a sound tetrahedron
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> (state_r == S_DIV && !degen_r))
    else $error("divider started outside divide phase");

  // MAC writebacks land only while faces are being processed
  a_mac_wb: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_q.valid |-> (state_r == S_MAC || state_r == S_DRAIN))
    else $error("MAC writeback outside face processing");

  // a finished query never overwrites an unaccepted result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !out_load)
    else $error("output register overwritten while stalled");

endmodule

`default_nettype wire

[tb/tetra_barycentric_coords_core_tb.sv]
// Testbench for tetra_barycentric_coords_core: directed rows, then random
// vertex loads and queries; each result beat is checked against a local model or its row.
// Depends on tbc_pkg and the core RTL.
`timescale 1ns / 1ps

module tetra_barycentric_coords_core_tb;
  import tbc_pkg::*;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;
  localparam int   ONE       = 65536;         // 1.0 in Q7.16
  localparam int   CMAX      = 8388607;
  localparam int   CMIN      = -8388608;
  localparam int   IDLE_LIMIT = 5000;         // cycles with no beat at all
  localparam int   HOLD_CYCLES = 900;         // long output back-pressure

  typedef struct {
    logic signed [CW-1:0] w [4];
    logic                 degen;
  } weights_t;

  typedef struct {
    logic                 req;
    logic [1:0]           idx;
    logic signed [CW-1:0] x, y, z;
    logic                 typed;   // expected result written in the row
    weights_t             res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_req_type = 1'b0;
  logic [1:0] in_vertex_index = '0;
  logic signed [CW-1:0] in_coord_x = '0, in_coord_y = '0, in_coord_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [CW-1:0] out_bary_0, out_bary_1, out_bary_2, out_bary_3;
  logic out_degenerate;

  always #1 clk = ~clk;

  tetra_barycentric_coords_core uut (
    .clk, .rst_n, .in_valid, .in_ready, .in_req_type, .in_vertex_index,
    .in_coord_x, .in_coord_y, .in_coord_z, .out_valid, .out_ready,
    .out_bary_0, .out_bary_1, .out_bary_2, .out_bary_3, .out_degenerate
  );

  // model copy of the vertex registers
  logic signed [CW-1:0] vtx [4][3];
  weights_t  pending_weights [$];
  stim_row_t stim_rows [$];
  int  errors = 0;
  int  idle_cycles = 0;
  bit  stim_done = 1'b0;
  bit  hold_req = 1'b0;
  bit  no_idle = 1'b0;     // stretches where both sides run flat out

  // Q16 ratio, truncated toward zero, saturated to 24 bits
  function automatic logic signed [CW-1:0] q16_ratio(logic signed [127:0] num,
                                                     logic signed [127:0] den);
    logic [127:0] an, ad, q;
    logic neg;
    if (num == 0) return '0;
    neg = (num < 0) != (den < 0);
    an = (num < 0) ? -num : num;
    ad = (den < 0) ? -den : den;
    q = (an << 16) / ad;
    if (neg) return (q > 128'd8388608) ? CW'(CMIN) : CW'(-q);
    return (q > 128'd8388607) ? CW'(CMAX) : CW'(q);
  endfunction

  // four weights for point p against the stored tetrahedron
  function automatic weights_t bary_weights(logic signed [CW-1:0] px,
                                            logic signed [CW-1:0] py,
                                            logic signed [CW-1:0] pz);
    weights_t r;
    logic signed [127:0] num [4], den [4];
    logic signed [127:0] e1 [3], e2 [3], dv [3], dx [3], n [3], p [3];
    int g [3];
    int c;
    p[0] = px; p[1] = py; p[2] = pz;
    r.degen = 1'b0;
    for (int i = 0; i < 4; i++) begin
      c = 0;
      for (int j = 0; j < 4; j++) if (j != i) begin
        g[c] = j;
        c++;
      end
      for (int k = 0; k < 3; k++) begin
        e1[k] = 128'(vtx[g[1]][k]) - 128'(vtx[g[0]][k]);
        e2[k] = 128'(vtx[g[2]][k]) - 128'(vtx[g[0]][k]);
        dv[k] = 128'(vtx[i][k]) - 128'(vtx[g[0]][k]);
        dx[k] = p[k] - 128'(vtx[g[0]][k]);
      end
      n[0] = e1[1] * e2[2] - e1[2] * e2[1];
      n[1] = e1[2] * e2[0] - e1[0] * e2[2];
      n[2] = e1[0] * e2[1] - e1[1] * e2[0];
      num[i] = dx[0] * n[0] + dx[1] * n[1] + dx[2] * n[2];
      den[i] = dv[0] * n[0] + dv[1] * n[1] + dv[2] * n[2];
      if (den[i] == 0) r.degen = 1'b1;
    end
    for (int i = 0; i < 4; i++) r.w[i] = r.degen ? '0 : q16_ratio(num[i], den[i]);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int exp_v);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_v, $realtime);
  endtask

  function automatic void add_row(stim_row_t s);
    stim_rows.insert(stim_rows.size(), s);
  endfunction

  // drive one beat; gap cycles first, then hold valid until accepted
  task automatic send_beat(stim_row_t row, int gap);
    weights_t r;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_req_type <= row.req;
    in_vertex_index <= row.idx;
    in_coord_x <= row.x;
    in_coord_y <= row.y;
    in_coord_z <= row.z;
    do @(posedge clk); while (!in_ready);
    if (row.req == REQ_LOAD) begin
      vtx[row.idx][0] = row.x;
      vtx[row.idx][1] = row.y;
      vtx[row.idx][2] = row.z;
    end else begin
      if (row.typed) r = row.res;
      else r = bary_weights(row.x, row.y, row.z);
      pending_weights.insert(pending_weights.size(), r);
    end
  endtask

  function automatic stim_row_t mk(logic req, logic [1:0] idx, int x, int y, int z);
    stim_row_t s;
    s.req = req; s.idx = idx; s.x = CW'(x); s.y = CW'(y); s.z = CW'(z);
    s.typed = 1'b0;
    s.res.degen = 1'b0;
    for (int i = 0; i < 4; i++) s.res.w[i] = '0;
    return s;
  endfunction

  function automatic stim_row_t mkq(int x, int y, int z, int w0, int w1, int w2,
                                    int w3, logic dg);
    stim_row_t s;
    s = mk(REQ_QUERY, 2'd0, x, y, z);
    s.typed = 1'b1;
    s.res.w[0] = CW'(w0); s.res.w[1] = CW'(w1);
    s.res.w[2] = CW'(w2); s.res.w[3] = CW'(w3);
    s.res.degen = dg;
    return s;
  endfunction

  function automatic int rand_coord(int mode);
    case (mode)
      0: return int'($signed(24'($urandom)));                      // full range
      1: return int'($urandom_range(0, 2 * ONE * 4)) - ONE * 4;    // modest
      default: return int'($urandom_range(0, 2 * ONE)) - ONE;      // small
    endcase
  endfunction

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, 9);
  endfunction

  // sender
  initial begin
    int n_items, mode, nq;
    stim_row_t s;
    for (int v = 0; v < 4; v++) for (int k = 0; k < 3; k++) vtx[v][k] = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // directed rows
    add_row(mkq(0, 0, 0, 0, 0, 0, 0, 1'b1));          // all vertices zero
    add_row(mkq(CMAX, CMIN, CMAX, 0, 0, 0, 0, 1'b1));
    add_row(mk(REQ_LOAD, 2'd0, 0, 0, 0));
    add_row(mk(REQ_LOAD, 2'd1, ONE, 0, 0));
    add_row(mk(REQ_LOAD, 2'd2, 0, ONE, 0));
    add_row(mk(REQ_LOAD, 2'd3, 0, 0, ONE));
    add_row(mkq(0, 0, 0, ONE, 0, 0, 0, 1'b0));        // at vertex 0
    add_row(mkq(ONE, 0, 0, 0, ONE, 0, 0, 1'b0));      // at vertex 1
    add_row(mkq(0, 0, ONE, 0, 0, 0, ONE, 1'b0));      // at vertex 3
    add_row(mk(REQ_QUERY, 2'd3, ONE / 4, ONE / 4, ONE / 4));
    add_row(mk(REQ_QUERY, 2'd1, CMAX, CMAX, CMAX));   // w0 saturates low
    add_row(mk(REQ_QUERY, 2'd2, CMIN, CMIN, CMIN));   // w0 saturates high
    add_row(mk(REQ_QUERY, 2'd0, ONE / 3, 0, 0));      // about a third of the way to vertex 1
    add_row(mk(REQ_LOAD, 2'd3, CMAX, CMAX, CMAX));
    add_row(mk(REQ_LOAD, 2'd2, CMIN, CMIN, CMAX));
    add_row(mk(REQ_LOAD, 2'd1, CMAX, CMIN, CMIN));
    add_row(mk(REQ_LOAD, 2'd0, CMIN, CMAX, CMIN));
    add_row(mk(REQ_QUERY, 2'd0, 0, 0, 0));
    add_row(mk(REQ_QUERY, 2'd0, CMAX, CMIN, CMAX));
    add_row(mk(REQ_LOAD, 2'd3, CMIN, CMIN, CMAX));    // vertex 3 = vertex 2
    add_row(mkq(5, -7, 9, 0, 0, 0, 0, 1'b1));
    foreach (stim_rows[i]) send_beat(stim_rows[i], draw_gap());
    n_items = stim_rows.size();

    // random: mostly full tetrahedra followed by queries, some noise
    while (n_items < 1300) begin
      no_idle = ($urandom_range(0, 7) == 0);
      if (n_items > 300 && n_items < 320) hold_req = 1'b1;
      if ($urandom_range(0, 9) == 0) begin
        s = mk(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), rand_coord(0),
               rand_coord(0), rand_coord(0));
        send_beat(s, draw_gap());
        n_items++;
      end else begin
        mode = $urandom_range(0, 2);
        for (int v = 0; v < 4; v++) begin
          s = mk(REQ_LOAD, 2'(v), rand_coord(mode), rand_coord(mode), rand_coord(mode));
          // sometimes repeat an earlier vertex to flatten the tetrahedron
          if (v > 0 && $urandom_range(0, 11) == 0) begin
            s.x = vtx[0][0]; s.y = vtx[0][1]; s.z = vtx[0][2];
          end
          send_beat(s, draw_gap());
          n_items++;
        end
        nq = $urandom_range(1, 8);
        for (int q = 0; q < nq; q++) begin
          s = mk(REQ_QUERY, 2'($urandom_range(0, 3)), rand_coord($urandom_range(mode, 2)),
                 rand_coord($urandom_range(mode, 2)), rand_coord($urandom_range(mode, 2)));
          send_beat(s, draw_gap());
          n_items++;
        end
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // receiver and checker
  initial begin
    weights_t e;
    int gap;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        gap = HOLD_CYCLES;      // sender keeps offering; the core must stall
      end else begin
        gap = draw_gap();
      end
      repeat (gap) begin
        @(negedge clk);
        out_ready <= 1'b0;
      end
      @(negedge clk);
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      if (pending_weights.size() == 0) begin
        report_mismatch("result beat count", 1, 0);
      end else begin
        e = pending_weights.pop_front();
        if (out_bary_0 !== e.w[0]) report_mismatch("bary_0", out_bary_0, e.w[0]);
        if (out_bary_1 !== e.w[1]) report_mismatch("bary_1", out_bary_1, e.w[1]);
        if (out_bary_2 !== e.w[2]) report_mismatch("bary_2", out_bary_2, e.w[2]);
        if (out_bary_3 !== e.w[3]) report_mismatch("bary_3", out_bary_3, e.w[3]);
        if (out_degenerate !== e.degen)
          report_mismatch("degenerate", out_degenerate, e.degen);
      end
    end
  end

  // watchdog: any beat on either channel resets the count
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // end of run: drain, settle, then verdict
  initial begin
    wait (stim_done);
    while (pending_weights.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (pending_weights.size() != 0)
      report_mismatch("results missing", 0, pending_weights.size());
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
src/tbc_pkg.sv
src/tbc_mac.sv
src/tbc_div.sv
src/tetra_barycentric_coords_core.sv
tb/tetra_barycentric_coords_core_tb.sv
